>>> hdl/delayed_event_timer_table_top_macros.svh
// Assertion macros shared by the timer table modules.
`ifndef DELAYED_EVENT_TIMER_TABLE_TOP_MACROS_SVH
`define DELAYED_EVENT_TIMER_TABLE_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define DETT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Implication also checked during reset.
`define DETT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> hdl/dett_pkg.sv
// Package with the shared types and codes of the delayed event timer table.
package dett_pkg;
  localparam int unsigned DefSlots = 32;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_FIRE     = 3'd0,
    KIND_INSERTED = 3'd1,
    KIND_FULL     = 3'd2,
    KIND_REMOVED  = 3'd3,
    KIND_DEADLINE = 3'd4
  } kind_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] handler;
    logic [31:0] argument;
    logic        any_argument;
    logic [31:0] delay;
    logic [31:0] elapsed;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] fired_handler;
    logic [31:0] fired_argument;
    logic        removed;
    logic        pending;
    logic [31:0] min_delay;
    logic        last;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_EMIT,
    ST_FINISH
  } state_t;
endpackage

>>> hdl/delayed_event_timer_table_top.sv
// Top level of the delayed event timer table.
//  channel | direction | handshake
//  in      | request   | in_valid / in_stall
//  out     | result    | out_valid / out_stall
// Immediate inserts answer in the cycle after they are taken, which waits until
// every earlier request has been answered. Other requests sweep the table
// slot by slot, pausing to emit each fired event, and end with one result.
// Reset clears all valid bits at once; no clearing pass is needed.
// Either side may stall; a two-entry queue parts the front from the sweep.
module delayed_event_timer_table_top #(
  parameter int unsigned SLOTS = dett_pkg::DefSlots
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] handler,
  input  logic [31:0] argument,
  input  logic        any_argument,
  input  logic [31:0] delay,
  input  logic [31:0] elapsed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [31:0] fired_handler,
  output logic [31:0] fired_argument,
  output logic        removed,
  output logic        pending,
  output logic [31:0] min_delay,
  output logic        last
);
  import dett_pkg::*;

  cmd_t in_cmd, q_cmd;
  res_t fire_res, back_res, sel;
  logic fire_valid, back_valid, q_valid, q_pop;
  logic pick_fire;
  logic back_busy;

  assign in_cmd = '{op: op_t'(operation), handler: handler, argument: argument,
                    any_argument: any_argument, delay: delay, elapsed: elapsed};

  assign pick_fire = fire_valid;
  assign sel = pick_fire ? fire_res : back_res;
  assign out_valid = fire_valid || back_valid;

  dett_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .fire_valid(fire_valid), .fire_stall(out_stall), .fire_res(fire_res),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd), .back_busy(back_busy)
  );

  dett_back #(.SLOTS(SLOTS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .res_valid(back_valid), .res_stall(out_stall || fire_valid), .res(back_res),
    .busy(back_busy)
  );

  assign kind = sel.kind;
  assign fired_handler = sel.fired_handler;
  assign fired_argument = sel.fired_argument;
  assign removed = sel.removed;
  assign pending = sel.pending;
  assign min_delay = sel.min_delay;
  assign last = sel.last;
endmodule

>>> hdl/dett_front.sv
// Front part: answers immediate inserts, queues others, drops unused ops.
module dett_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  dett_pkg::cmd_t in_cmd,
  output logic         fire_valid,
  input  logic         fire_stall,
  output dett_pkg::res_t fire_res,
  output logic         q_valid,
  input  logic         q_pop,
  output dett_pkg::cmd_t q_cmd,
  input  logic         back_busy
);
  import dett_pkg::*;

  cmd_t q_data [2];
  logic [1:0] q_count;
  logic q_rd;
  logic q_wr;
  logic immediate;
  logic take;
  logic push;
  logic pop;

  // An immediate insert waits until every earlier request has left the block.
  assign immediate = (in_cmd.op == OP_INSERT) && (in_cmd.delay <= 32'd1);
  assign in_stall = immediate ? ((fire_valid && fire_stall) || q_valid || back_busy) :
                                (q_count == 2'd2);
  assign take = in_valid && !in_stall;
  assign push = take && !immediate && (in_cmd.op != OP_UNUSED);
  assign pop = q_pop && q_valid;
  assign q_valid = (q_count != 2'd0);
  assign q_cmd = q_data[q_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 2'd0;
      q_rd <= 1'b0;
      q_wr <= 1'b0;
      fire_valid <= 1'b0;
    end else begin
      if (push) begin
        q_wr <= ~q_wr;
      end
      if (pop) begin
        q_rd <= ~q_rd;
      end
      q_count <= q_count + {1'b0, push} - {1'b0, pop};
      if (take && immediate) begin
        fire_valid <= 1'b1;
      end else if (!fire_stall) begin
        fire_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_data[q_wr] <= in_cmd;
    end
    if (take && immediate) begin
      fire_res <= '{kind: KIND_FIRE, fired_handler: in_cmd.handler,
                    fired_argument: in_cmd.argument, removed: 1'b0,
                    pending: 1'b0, min_delay: 32'd0, last: 1'b1};
    end
  end

  `include "delayed_event_timer_table_top_macros.svh"
  `DETT_ASSERT(a_q_bound, clk, rst, q_count <= 2'd2, "queue count overflow")
  `DETT_ASSERT(a_no_push_full, clk, rst, push |-> q_count != 2'd2 || pop, "push into full queue")
  `DETT_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> q_count == 2'd0, "queue not empty after reset")
endmodule

>>> hdl/dett_back.sv
// Back part: sweeps the slot table for insert, remove and advance requests.
module dett_back #(
  parameter int unsigned SLOTS = dett_pkg::DefSlots
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  output logic         q_pop,
  input  dett_pkg::cmd_t q_cmd,
  output logic         res_valid,
  input  logic         res_stall,
  output dett_pkg::res_t res,
  output logic         busy
);
  import dett_pkg::*;
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW:0] LastIdx = (IW+1)'(SLOTS - 1);

  logic [SLOTS-1:0] slot_valid;
  logic [31:0] mem_handler [SLOTS];
  logic [31:0] mem_argument [SLOTS];
  logic [31:0] mem_remaining [SLOTS];

  state_t state, state_next;
  cmd_t cmd;
  logic [IW:0] idx;
  logic [IW-1:0] slot;
  logic found;
  logic [IW-1:0] free_slot;
  logic any_removed;
  logic pend;
  logic [31:0] best;
  logic [31:0] cur_h, cur_a, cur_r;
  logic cur_v;
  logic rd_ok;
  logic fire_hit;
  logic at_end;
  logic out_free;
  res_t fin_res;

  assign slot = idx[IW-1:0];
  assign at_end = (idx == LastIdx);
  assign out_free = !res_valid || !res_stall;
  assign q_pop = (state == ST_IDLE) && q_valid;
  assign fire_hit = cur_v && (cur_r <= cmd.elapsed);
  assign busy = (state != ST_IDLE) || res_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid) state_next = ST_SWEEP;
      ST_SWEEP: if (rd_ok && fire_hit && cmd.op == OP_ADVANCE) state_next = ST_EMIT;
                else if (rd_ok && at_end) state_next = ST_FINISH;
      ST_EMIT: if (out_free) state_next = at_end ? ST_FINISH : ST_SWEEP;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    fin_res = '0;
    fin_res.last = 1'b1;
    unique case (cmd.op)
      OP_INSERT: fin_res.kind = found ? KIND_INSERTED : KIND_FULL;
      OP_REMOVE: begin
        fin_res.kind = KIND_REMOVED;
        fin_res.removed = any_removed;
      end
      default: begin
        fin_res.kind = KIND_DEADLINE;
        fin_res.pending = pend;
        fin_res.min_delay = best;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      slot_valid <= '0;
      res_valid <= 1'b0;
      rd_ok <= 1'b0;
      idx <= '0;
    end else begin
      state <= state_next;
      if ((state == ST_EMIT || state == ST_FINISH) && out_free) res_valid <= 1'b1;
      else if (out_free) res_valid <= 1'b0;
      rd_ok <= (state == ST_SWEEP) && !rd_ok;
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
          found <= 1'b0;
          any_removed <= 1'b0;
          pend <= 1'b0;
          best <= 32'd0;
          if (q_valid) begin
            cmd <= q_cmd;
          end
        end
        ST_SWEEP: begin
          if (rd_ok) begin
            unique case (cmd.op)
              OP_INSERT: if (!cur_v && !found) begin
                found <= 1'b1;
                free_slot <= slot;
              end
              OP_REMOVE: if (cur_v && cur_h == cmd.handler &&
                             (cmd.any_argument || cur_a == cmd.argument)) begin
                slot_valid[slot] <= 1'b0;
                any_removed <= 1'b1;
              end
              default: if (cur_v) begin
                if (fire_hit) begin
                  slot_valid[slot] <= 1'b0;
                end else if (!pend || (cur_r - cmd.elapsed) < best) begin
                  pend <= 1'b1;
                  best <= cur_r - cmd.elapsed;
                end
              end
            endcase
            if (!(fire_hit && cmd.op == OP_ADVANCE) && !at_end) idx <= idx + 1'b1;
          end
        end
        ST_EMIT: if (out_free) begin
          if (!at_end) idx <= idx + 1'b1;
        end
        ST_FINISH: if (out_free) begin
          if (cmd.op == OP_INSERT && found) slot_valid[free_slot] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cur_v <= slot_valid[slot];
    cur_h <= mem_handler[slot];
    cur_a <= mem_argument[slot];
    cur_r <= mem_remaining[slot];
    if (state == ST_SWEEP && rd_ok && cmd.op == OP_ADVANCE && cur_v && !fire_hit) begin
      mem_remaining[slot] <= cur_r - cmd.elapsed;
    end
    if (state == ST_FINISH && out_free && cmd.op == OP_INSERT && found) begin
      mem_handler[free_slot] <= cmd.handler;
      mem_argument[free_slot] <= cmd.argument;
      mem_remaining[free_slot] <= cmd.delay;
    end
    if (state == ST_EMIT && out_free) begin
      res <= '{kind: KIND_FIRE, fired_handler: cur_h, fired_argument: cur_a,
               removed: 1'b0, pending: 1'b0, min_delay: 32'd0, last: 1'b0};
    end
    if (state == ST_FINISH && out_free) begin
      res <= fin_res;
    end
  end

  `include "delayed_event_timer_table_top_macros.svh"
  `DETT_ASSERT(a_pop_idle, clk, rst, q_pop |-> state == ST_IDLE, "pop outside idle")
  `DETT_ASSERT(a_idx_range, clk, rst, idx <= LastIdx, "slot index out of range")
  `DETT_ASSERT(a_hold, clk, rst, (res_valid && res_stall) |=> res_valid && $stable(res), "result dropped")
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the delayed event timer table.
module tb_top;
  import dett_pkg::*;

  localparam int Slots = 32;
  localparam int MaxShown = 10;

  typedef struct {
    op_t         op;
    logic [31:0] handler;
    logic [31:0] argument;
    logic        any_argument;
    logic [31:0] delay;
    logic [31:0] elapsed;
    bit          typed;
    res_t        typed_res;
  } row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  operation;
  logic [31:0] handler;
  logic [31:0] argument;
  logic        any_argument;
  logic [31:0] delay;
  logic [31:0] elapsed;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  kind;
  logic [31:0] fired_handler;
  logic [31:0] fired_argument;
  logic        removed;
  logic        pending;
  logic [31:0] min_delay;
  logic        last;

  bit          tbl_valid[Slots];
  logic [31:0] tbl_handler[Slots];
  logic [31:0] tbl_argument[Slots];
  logic [31:0] tbl_remaining[Slots];

  res_t        expected_results[$];
  int          mismatches;
  int          results_seen;
  int          fires_seen;
  int          requests_sent;
  int          stall_left;
  bit          fast_out;
  row_t        directed[$];

  delayed_event_timer_table_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .handler(handler), .argument(argument),
    .any_argument(any_argument), .delay(delay), .elapsed(elapsed),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .fired_handler(fired_handler), .fired_argument(fired_argument),
    .removed(removed), .pending(pending), .min_delay(min_delay), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Timeout with %0d results outstanding.", expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic res_t make_res(kind_t k, logic [31:0] fh, logic [31:0] fa,
                                    logic rm, logic pd, logic [31:0] nd, logic lst);
    res_t r;
    r.kind = k;
    r.fired_handler = fh;
    r.fired_argument = fa;
    r.removed = rm;
    r.pending = pd;
    r.min_delay = nd;
    r.last = lst;
    return r;
  endfunction

  function automatic int occupied_slots();
    int n;
    n = 0;
    foreach (tbl_valid[i]) n += tbl_valid[i];
    return n;
  endfunction

  // Applies one request to the table copy and queues the results it causes.
  task automatic predict_timer_results(row_t r);
    int          i;
    int          free_slot;
    bit          any_removed;
    bit          waiting;
    logic [31:0] soonest;
    free_slot = -1;
    any_removed = 1'b0;
    waiting = 1'b0;
    soonest = '0;
    case (r.op)
      OP_INSERT: begin
        if (r.delay <= 32'd1) begin
          expected_results.push_back(make_res(KIND_FIRE, r.handler, r.argument,
                                              1'b0, 1'b0, 0, 1'b1));
        end else begin
          for (i = Slots - 1; i >= 0; i--) if (!tbl_valid[i]) free_slot = i;
          if (free_slot < 0) begin
            expected_results.push_back(make_res(KIND_FULL, 0, 0, 1'b0, 1'b0, 0, 1'b1));
          end else begin
            tbl_valid[free_slot] = 1'b1;
            tbl_handler[free_slot] = r.handler;
            tbl_argument[free_slot] = r.argument;
            tbl_remaining[free_slot] = r.delay;
            expected_results.push_back(make_res(KIND_INSERTED, 0, 0, 1'b0, 1'b0, 0, 1'b1));
          end
        end
      end
      OP_REMOVE: begin
        for (i = 0; i < Slots; i++) begin
          if (tbl_valid[i] && tbl_handler[i] == r.handler &&
              (r.any_argument || tbl_argument[i] == r.argument)) begin
            tbl_valid[i] = 1'b0;
            any_removed = 1'b1;
          end
        end
        expected_results.push_back(make_res(KIND_REMOVED, 0, 0, any_removed, 1'b0, 0, 1'b1));
      end
      OP_ADVANCE: begin
        for (i = 0; i < Slots; i++) begin
          if (tbl_valid[i]) begin
            if (tbl_remaining[i] > r.elapsed) begin
              tbl_remaining[i] = tbl_remaining[i] - r.elapsed;
            end else begin
              tbl_valid[i] = 1'b0;
              expected_results.push_back(make_res(KIND_FIRE, tbl_handler[i],
                                                  tbl_argument[i], 1'b0, 1'b0, 0, 1'b0));
            end
          end
        end
        for (i = 0; i < Slots; i++) begin
          if (tbl_valid[i] && (!waiting || tbl_remaining[i] < soonest)) begin
            soonest = tbl_remaining[i];
            waiting = 1'b1;
          end
        end
        expected_results.push_back(make_res(KIND_DEADLINE, 0, 0, 1'b0, waiting, soonest, 1'b1));
      end
      default: ;
    endcase
  endtask

  // Updates the table copy for a row whose result was typed into the table.
  task automatic predict_quiet(row_t r);
    int keep;
    keep = expected_results.size();
    predict_timer_results(r);
    while (expected_results.size() > keep) void'(expected_results.pop_back());
  endtask

  task automatic send_request(row_t r);
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 :
          (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= r.op;
    handler <= r.handler;
    argument <= r.argument;
    any_argument <= r.any_argument;
    delay <= r.delay;
    elapsed <= r.elapsed;
    if (r.typed) expected_results.push_back(r.typed_res);
    else predict_timer_results(r);
    if (r.typed) predict_quiet(r);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  function automatic row_t mk(op_t op, logic [31:0] h, logic [31:0] a, logic aa,
                              logic [31:0] d, logic [31:0] e);
    row_t r;
    r.op = op;
    r.handler = h;
    r.argument = a;
    r.any_argument = aa;
    r.delay = d;
    r.elapsed = e;
    r.typed = 1'b0;
    r.typed_res = '0;
    return r;
  endfunction

  function automatic row_t mk_typed(row_t r, res_t x);
    r.typed = 1'b1;
    r.typed_res = x;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (fast_out) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 29) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(10, 40);
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      got = make_res(kind_t'(kind), fired_handler, fired_argument, removed, pending,
                     min_delay, last);
      results_seen++;
      if (kind == KIND_FIRE) fires_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown) $display("Unexpected result %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MaxShown) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    row_t r;
    int   i;
    int   h_pool[4];
    int   wait_cycles;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_INSERT;
    handler = '0;
    argument = '0;
    any_argument = 1'b0;
    delay = '0;
    elapsed = '0;
    fast_out = 1'b0;
    mismatches = 0;
    results_seen = 0;
    fires_seen = 0;
    requests_sent = 0;
    foreach (tbl_valid[k]) begin
      tbl_valid[k] = 1'b0;
      tbl_handler[k] = '0;
      tbl_argument[k] = '0;
      tbl_remaining[k] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(mk_typed(mk(OP_ADVANCE, 0, 0, 1'b0, 0, 0),
                                make_res(KIND_DEADLINE, 0, 0, 1'b0, 1'b0, 0, 1'b1)));
    directed.push_back(mk_typed(mk(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0,
                                   32'hFFFF_FFFF),
                                make_res(KIND_FIRE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                         1'b0, 1'b0, 0, 1'b1)));
    directed.push_back(mk_typed(mk(OP_INSERT, 0, 0, 1'b0, 1, 0),
                                make_res(KIND_FIRE, 0, 0, 1'b0, 1'b0, 0, 1'b1)));
    directed.push_back(mk_typed(mk(OP_REMOVE, 0, 0, 1'b1, 0, 0),
                                make_res(KIND_REMOVED, 0, 0, 1'b0, 1'b0, 0, 1'b1)));
    directed.push_back(mk_typed(mk(OP_INSERT, 0, 0, 1'b0, 32'hFFFF_FFFF, 0),
                                make_res(KIND_INSERTED, 0, 0, 1'b0, 1'b0, 0, 1'b1)));
    directed.push_back(mk_typed(mk(OP_ADVANCE, 0, 0, 1'b0, 0, 0),
                                make_res(KIND_DEADLINE, 0, 0, 1'b0, 1'b1, 32'hFFFF_FFFF,
                                         1'b1)));
    directed.push_back(mk(OP_INSERT, 32'h1234, 32'h55, 1'b0, 2, 0));
    directed.push_back(mk(OP_INSERT, 32'h1234, 32'h66, 1'b0, 3, 0));
    directed.push_back(mk(OP_INSERT, 32'hABCD, 32'h77, 1'b0, 2, 0));
    directed.push_back(mk(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(mk(OP_REMOVE, 32'h1234, 32'h66, 1'b0, 0, 0));
    directed.push_back(mk(OP_REMOVE, 32'h1234, 32'h0, 1'b0, 0, 0));
    directed.push_back(mk(OP_ADVANCE, 0, 0, 1'b0, 0, 1));
    directed.push_back(mk(OP_ADVANCE, 0, 0, 1'b0, 0, 1));
    directed.push_back(mk(OP_REMOVE, 32'h1234, 32'h0, 1'b1, 0, 0));
    for (i = 0; i < Slots; i++) directed.push_back(mk(OP_INSERT, i, ~i, 1'b0, 2 + i, 0));
    directed.push_back(mk(OP_INSERT, 32'h9, 32'h9, 1'b0, 5, 0));
    directed.push_back(mk(OP_ADVANCE, 0, 0, 1'b0, 0, 32'hFFFF_FFFF));

    foreach (directed[k]) send_request(directed[k]);
    in_valid <= 1'b0;

    // The sender holds back here until the block has drained completely.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    for (i = 0; i < 4; i++) h_pool[i] = rand_word();
    for (i = 0; i < 130; i++) begin
      r = mk(OP_INSERT, h_pool[$urandom_range(0, 3)], $urandom_range(0, 3), 1'b0, 0, 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          r.op = OP_INSERT;
          r.delay = ($urandom_range(0, 5) == 0) ? rand_word() : $urandom_range(0, 400);
        end
        4, 5: begin
          r.op = OP_REMOVE;
          r.any_argument = 1'($urandom_range(0, 1));
        end
        6, 7, 8: begin
          r.op = OP_ADVANCE;
          r.elapsed = ($urandom_range(0, 7) == 0) ? rand_word() : $urandom_range(0, 120);
        end
        default: begin
          r = mk(op_t'(2'($urandom_range(0, 3))), rand_word(), rand_word(),
                 1'($urandom_range(0, 1)), rand_word(), rand_word());
        end
      endcase
      if (occupied_slots() > 28 && $urandom_range(0, 1)) r.op = OP_ADVANCE;
      fast_out = (i > 110);
      send_request(r);
    end
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 200_000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);

    $display("Sent %0d requests and checked %0d results, %0d of them fired events.",
             requests_sent, results_seen, fires_seen);
    $display("Mismatches: %0d, results still outstanding: %0d.",
             mismatches, expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
